// ===== rtl/link_latency_and_loss_window_top_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LINK_LATENCY_AND_LOSS_WINDOW_TOP_MACROS_SVH
`define LINK_LATENCY_AND_LOSS_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LLW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LLW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/llw_pkg.sv =====
`timescale 1ns / 1ps
package llw_pkg;

  // Default number of samples held in the window.
  localparam int WINDOW_DEPTH_DEFAULT = 64;
  // Reset value of the window length register in milliseconds.
  localparam logic [31:0] WINDOW_MS_RESET = 32'd10000;

  // Request codes.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Register indexes.
  localparam logic REG_WINDOW_MS = 1'b0;

  // Number of quotient bits of the loss rate.
  localparam int RATE_W = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
    logic div_step;
    logic out_load;
  } llw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic res_full;
  } llw_stat_t;

endpackage

// ===== rtl/llw_req_if.sv =====
`timescale 1ns / 1ps
interface llw_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] sender_time_ms;
  logic [31:0] local_time_ms;
  logic [15:0] frags_received;
  logic [15:0] frags_lost;

  modport source (
    output valid, req_type, sender_time_ms, local_time_ms, frags_received, frags_lost,
    input  ready
  );
  modport sink (
    input  valid, req_type, sender_time_ms, local_time_ms, frags_received, frags_lost,
    output ready
  );
endinterface

// ===== rtl/llw_res_if.sv =====
`timescale 1ns / 1ps
interface llw_res_if #(
  parameter int ENTRY_W = $clog2(llw_pkg::WINDOW_DEPTH_DEFAULT + 1)
);
  logic               valid;
  logic               ready;
  logic [31:0]        latency_ms;
  logic [16:0]        loss_rate_q16;
  logic               time_backwards;
  logic               no_fragments;
  logic               window_evicted;
  logic [ENTRY_W-1:0] window_entries;

  modport source (
    output valid, latency_ms, loss_rate_q16, time_backwards, no_fragments,
           window_evicted, window_entries,
    input  ready
  );
  modport sink (
    input  valid, latency_ms, loss_rate_q16, time_backwards, no_fragments,
           window_evicted, window_entries,
    output ready
  );
endinterface

// ===== rtl/llw_ram.sv =====
`timescale 1ns / 1ps
module llw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/llw_ctrl.sv =====
`timescale 1ns / 1ps
module llw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_clear,
  output logic              in_ready,
  input  llw_pkg::llw_stat_t stat,
  output llw_pkg::llw_cmd_t  cmd
);
  import llw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and the command for the datapath.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = in_clear ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!stat.res_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ===== rtl/llw_datapath.sv =====
`timescale 1ns / 1ps
module llw_datapath #(
  parameter int WINDOW_DEPTH = llw_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  llw_pkg::llw_cmd_t                   cmd,
  output llw_pkg::llw_stat_t                  stat,
  input  logic [31:0]                         window_ms,
  input  logic                                req_type,
  input  logic [31:0]                         sender_time_ms,
  input  logic [31:0]                         local_time_ms,
  input  logic [15:0]                         frags_received,
  input  logic [15:0]                         frags_lost,
  input  logic                                res_ready,
  output logic                                res_valid,
  output logic [31:0]                         latency_ms,
  output logic [16:0]                         loss_rate_q16,
  output logic                                time_backwards,
  output logic                                no_fragments,
  output logic                                window_evicted,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]   window_entries
);
  import llw_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 16 + CW;
  localparam logic [CW:0]   DEPTH_W   = (CW+1)'(WINDOW_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
  localparam logic [CW-1:0] LAST_C    = CW'(WINDOW_DEPTH - 1);
  localparam logic [4:0]    DIV_STEPS = 5'(RATE_W);

  // Logical window position to memory address, relative to the oldest entry.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(idx);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // Persistent state.
  logic [31:0]     prev_sender;
  logic [31:0]     prev_local;
  logic [31:0]     lat;
  logic [16:0]     rate;
  logic [CW-1:0]   count;
  logic [AW-1:0]   base;

  // Per-request working registers.
  logic [31:0]     t_lat;
  logic [15:0]     rcv_lat;
  logic [15:0]     lst_lat;
  logic            backwards;
  logic            nofrag;
  logic            evicted;
  logic [CW-1:0]   src;
  logic [CW-1:0]   dst;
  logic            pend;
  logic [SW-1:0]   sum_r;
  logic [SW-1:0]   sum_l;
  logic [15:0]     first_r;
  logic [15:0]     first_l;
  logic [SW:0]     den;
  logic [SW+1:0]   rem;
  logic [16:0]     quo;
  logic [4:0]      div_cnt;

  // Memory port signals.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [63:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [63:0]     ram_rdata;

  logic [31:0]     lat_next;
  logic            backwards_next;
  logic [31:0]     elapsed_snd;
  logic [31:0]     elapsed_loc;
  logic [33:0]     lat_sum;
  logic            keep;
  logic            evict;
  logic [CW-1:0]   cnt_eff;
  logic [AW-1:0]   base_eff;
  logic [SW-1:0]   sr_fin;
  logic [SW-1:0]   sl_fin;
  logic [SW+1:0]   rem_sh;
  logic            qbit;

  // Latency update from the new report.
  always_comb begin
    elapsed_snd    = sender_time_ms - prev_sender;
    elapsed_loc    = local_time_ms - prev_local;
    lat_sum        = {2'b00, lat} + {2'b00, elapsed_loc} - {2'b00, elapsed_snd};
    lat_next       = lat;
    backwards_next = 1'b0;
    if (prev_sender != 32'd0) begin
      if (sender_time_ms >= prev_sender) begin
        if (lat_sum[33]) begin
          lat_next = 32'd0;
        end else if (lat_sum[32]) begin
          lat_next = 32'hFFFF_FFFF;
        end else begin
          lat_next = lat_sum[31:0];
        end
      end else begin
        backwards_next = 1'b1;
      end
    end
  end

  // Expiry test on the entry read back this cycle.
  assign keep = !((t_lat >= window_ms) && (ram_rdata[63:32] < (t_lat - window_ms)));

  // End of the scan: eviction of a full window and the new sample.
  always_comb begin
    evict    = (dst == DEPTH_C);
    cnt_eff  = evict ? LAST_C : dst;
    base_eff = evict ? phys(base, CW'(1)) : base;
    sr_fin   = sum_r - (evict ? SW'(first_r) : SW'(0)) + SW'(rcv_lat);
    sl_fin   = sum_l - (evict ? SW'(first_l) : SW'(0)) + SW'(lst_lat);
  end

  // Memory address and write selection.
  always_comb begin
    ram_raddr = phys(base, src);
    ram_we    = 1'b0;
    ram_waddr = phys(base, dst);
    ram_wdata = ram_rdata;
    if (cmd.scan && pend && keep) begin
      ram_we = 1'b1;
    end else if (cmd.finish) begin
      ram_we    = 1'b1;
      ram_waddr = phys(base_eff, cnt_eff);
      ram_wdata = {t_lat, lst_lat, rcv_lat};
    end
  end

  // One restoring division step.
  always_comb begin
    rem_sh = (div_cnt == 5'd0) ? rem : {rem[SW:0], 1'b0};
    qbit   = (rem_sh >= (SW+2)'(den));
  end

  llw_ram #(
    .WIDTH(64),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state of the window and the estimates.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sender <= 32'd0;
      prev_local  <= 32'd0;
      lat         <= 32'd0;
      rate        <= 17'd0;
      count       <= '0;
      base        <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (req_type == REQ_CLEAR) begin
          prev_sender <= 32'd0;
          prev_local  <= 32'd0;
          lat         <= 32'd0;
          rate        <= 17'd0;
          count       <= '0;
          base        <= '0;
        end else begin
          prev_sender <= sender_time_ms;
          prev_local  <= local_time_ms;
          lat         <= lat_next;
        end
      end
      if (cmd.finish) begin
        count <= cnt_eff + CW'(1);
        base  <= base_eff;
      end
      if (cmd.out_load) begin
        if (!nofrag) begin
          rate <= quo;
        end
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current request and the result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_lat     <= sender_time_ms;
      rcv_lat   <= frags_received;
      lst_lat   <= frags_lost;
      backwards <= (req_type == REQ_CLEAR) ? 1'b0 : backwards_next;
      nofrag    <= 1'b0;
      evicted   <= 1'b0;
      src       <= '0;
      dst       <= '0;
      pend      <= 1'b0;
      sum_r     <= '0;
      sum_l     <= '0;
      quo       <= '0;
    end
    if (cmd.scan) begin
      pend <= (src != count);
      if (src != count) begin
        src <= src + CW'(1);
      end
      if (pend && keep) begin
        dst   <= dst + CW'(1);
        sum_r <= sum_r + SW'(ram_rdata[15:0]);
        sum_l <= sum_l + SW'(ram_rdata[31:16]);
        if (dst == '0) begin
          first_r <= ram_rdata[15:0];
          first_l <= ram_rdata[31:16];
        end
      end
    end
    if (cmd.finish) begin
      evicted <= evict;
      nofrag  <= (sr_fin == '0);
      den     <= (SW+1)'(sr_fin) + (SW+1)'(sl_fin);
      rem     <= (SW+2)'(sl_fin);
      div_cnt <= 5'd0;
    end
    if (cmd.div_step) begin
      rem     <= qbit ? (rem_sh - (SW+2)'(den)) : rem_sh;
      quo     <= {quo[15:0], qbit};
      div_cnt <= div_cnt + 5'd1;
    end
    if (cmd.out_load) begin
      latency_ms     <= lat;
      loss_rate_q16  <= nofrag ? rate : quo;
      time_backwards <= backwards;
      no_fragments   <= nofrag;
      window_evicted <= evicted;
      window_entries <= count;
    end
  end

  assign stat.scan_done = (src == count) && !pend;
  assign stat.div_done  = (div_cnt == DIV_STEPS);
  assign stat.res_full  = res_valid;

endmodule

// ===== rtl/link_latency_and_loss_window_top.sv =====
`timescale 1ns / 1ps
// Link latency and loss window estimator.
// Requests arrive on the req channel (valid/ready); a transaction is taken at
// a clock edge where both are high. An add request updates the latency estimate
// and stores its fragment counts in a window of WINDOW_DEPTH samples; a clear
// request empties all state and returns a result of all zeros.
// Every request gives exactly one transaction on the res channel.
// For an add request the window memory is scanned one entry a cycle through its
// single read port, then a 17-step serial divider forms the Q1.16 loss rate.
// A clear request skips the scan and the division and goes to the output state.
// The result register parts the two channels: a new request is taken while a
// result still waits, and a stalled receiver holds the block only when the
// next result is ready to leave.
// The window_ms register is written over the APB port at address 0 and keeps
// its value across clear requests. After reset the window is empty, all
// estimates are zero and window_ms is 10000.
module link_latency_and_loss_window_top #(
  parameter int WINDOW_DEPTH = llw_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  llw_req_if.sink     req,
  llw_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import llw_pkg::*;

  logic [31:0] window_ms;
  llw_cmd_t    cmd;
  llw_stat_t   stat;
  logic        res_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_MS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_MS)) begin
      window_ms <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_MS) ? window_ms : 32'd0;

  llw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_clear(req.req_type == REQ_CLEAR),
    .in_ready(req.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  llw_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .window_ms     (window_ms),
    .req_type      (req.req_type),
    .sender_time_ms(req.sender_time_ms),
    .local_time_ms (req.local_time_ms),
    .frags_received(req.frags_received),
    .frags_lost    (req.frags_lost),
    .res_ready     (res.ready),
    .res_valid     (res_valid),
    .latency_ms    (res.latency_ms),
    .loss_rate_q16 (res.loss_rate_q16),
    .time_backwards(res.time_backwards),
    .no_fragments  (res.no_fragments),
    .window_evicted(res.window_evicted),
    .window_entries(res.window_entries)
  );

  assign res.valid = res_valid;

endmodule

// ===== rtl/llw_checker.sv =====
`timescale 1ns / 1ps
`include "link_latency_and_loss_window_top_macros.svh"
module llw_checker #(
  parameter int WINDOW_DEPTH = llw_pkg::WINDOW_DEPTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [31:0]                       latency_ms,
  input logic [16:0]                       loss_rate_q16,
  input logic                              time_backwards,
  input logic                              no_fragments,
  input logic                              window_evicted,
  input logic [$clog2(WINDOW_DEPTH+1)-1:0] window_entries,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [2:0]                        paddr,
  input logic [31:0]                       pwdata,
  input logic [31:0]                       prdata
);

  localparam int EW = $clog2(WINDOW_DEPTH + 1);

  // A stalled result keeps its payload.
  `LLW_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(latency_ms) && $stable(loss_rate_q16) && $stable(window_entries), "result changed while stalled")

  // The loss rate never passes one and the window never overfills.
  `LLW_ASSERT_IMP(a_res_range, clk, rst, res_valid, (loss_rate_q16 <= 17'd65536) && (window_entries <= EW'(WINDOW_DEPTH)), "result out of range")

  // An empty window only follows a clear, whose result is all zeros.
  `LLW_ASSERT_IMP(a_clear_zero, clk, rst, res_valid && (window_entries == '0), (latency_ms == 32'd0) && (loss_rate_q16 == 17'd0) && !time_backwards && !no_fragments && !window_evicted, "clear result not zero")

  // A register write is read back on the next cycle.
  `LLW_ASSERT_NXT(a_cfg_readback, clk, rst, psel && penable && pwrite && !paddr[2], paddr[2] || (prdata == $past(pwdata)), "window register readback mismatch")

endmodule

bind link_latency_and_loss_window_top llw_checker #(
  .WINDOW_DEPTH(WINDOW_DEPTH)
) u_llw_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .latency_ms    (res.latency_ms),
  .loss_rate_q16 (res.loss_rate_q16),
  .time_backwards(res.time_backwards),
  .no_fragments  (res.no_fragments),
  .window_evicted(res.window_evicted),
  .window_entries(res.window_entries),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
